// File: hw/rtl/tes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_pkg
// Types, codes and per-byte helper functions for the text encoding sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

    // encoding codes
    localparam logic [2:0] ENC_ASCII   = 3'd0;
    localparam logic [2:0] ENC_UNKNOWN = 3'd1;
    localparam logic [2:0] ENC_ASCIICP = 3'd2;
    localparam logic [2:0] ENC_UTF8    = 3'd3;
    localparam logic [2:0] ENC_UTF16LE = 3'd4;
    localparam logic [2:0] ENC_UTF16BE = 3'd5;

    // byte order mark bytes
    localparam logic [7:0] BOM_FF = 8'hFF;
    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;

    // lead byte masks and patterns
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;

    localparam int HEAD_DEPTH = 4;
    localparam logic [2:0] HEAD_FULL = 3'd4;

    typedef struct packed {
        logic multi;
        logic invalid;
        logic binary;
    } tes_flags_t;

    typedef struct packed {
        logic [1:0] pending;
        tes_flags_t flags;
        logic       stopped;
    } tes_scan_t;

    typedef logic [7:0] tes_head_t [HEAD_DEPTH];

    // one step of the utf-8 scan
    function automatic tes_scan_t scan_byte(tes_scan_t s, logic [7:0] b);
        tes_scan_t r;
        logic      done;
        r    = s;
        done = 1'b0;
        if (!s.stopped) begin
            if (s.pending != 2'd0) begin
                if (b inside {[8'h80:8'hBF]}) begin
                    r.pending = s.pending - 2'd1;
                    done      = 1'b1;
                end
                else begin
                    // bad continuation, then treat as lead byte
                    r.flags.invalid = 1'b1;
                    r.pending       = 2'd0;
                end
            end
            if (!done && !(b inside {[8'h20:8'h7E], 8'h09, 8'h0A, 8'h0D})) begin
                if (b < 8'h20) begin
                    r.flags.binary = 1'b1;
                    r.stopped      = 1'b1;
                end
                else if (b inside {[8'h80:8'hBF]}) begin
                    r.flags.invalid = 1'b1;
                    r.stopped       = 1'b1;
                end
                else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
                    r.pending     = 2'd1;
                    r.flags.multi = 1'b1;
                end
                else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
                    r.pending     = 2'd2;
                    r.flags.multi = 1'b1;
                end
                else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
                    r.pending     = 2'd3;
                    r.flags.multi = 1'b1;
                end
                else begin
                    // 7f and f8..ff
                    r.flags.invalid = 1'b1;
                    r.stopped       = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // final decision from header bytes and scan flags
    function automatic logic [2:0] decide(logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3,
                                          tes_flags_t f);
        logic [2:0] e;
        if (b0 == BOM_FF && b1 == BOM_FE)
            e = ENC_UTF16LE;
        else if (b0 == BOM_FE && b1 == BOM_FF)
            e = ENC_UTF16BE;
        else if (b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF)
            e = ENC_UTF8;
        else if (b0 != 8'd0 && b1 == 8'd0 && b2 != 8'd0 && b3 == 8'd0)
            e = ENC_UTF16LE;
        else if (b0 == 8'd0 && b1 != 8'd0 && b2 == 8'd0 && b3 != 8'd0)
            e = ENC_UTF16BE;
        else if (f.binary)
            e = ENC_UNKNOWN;
        else if (f.invalid)
            e = ENC_ASCIICP;
        else if (f.multi)
            e = ENC_UTF8;
        else
            e = ENC_ASCII;
        return e;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/text_encoding_sniffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_encoding_sniffer_top
// Guesses the encoding of a byte stream buffer and reports it on its last byte.
//
// input channel: in_valid / in_ready carry data_byte and last; one byte per
//   transfer, last marks the final byte of a buffer
// output channel: out_valid / out_ready carry encoding, one transfer per
//   buffer (none for bytes without last)
// a transferred byte lands in an input register; from that register the
//   header capture, utf-8 scan step and decision run into the state and the
//   result register
// result path: the last byte passes the input register, then the result register
// throughput: one byte per cycle, set by the single scan step, except in the stall below
// stall: while a result waits in the output register, non-last bytes keep
//   flowing; a second last byte waits in the input register and in_ready
//   drops until the pending result is taken
// reset: all scan state, header bytes and valid flags clear; the first byte
//   after reset starts a new buffer, as does the byte after every last
// ----------------------------------------------------------------------------
module text_encoding_sniffer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      encoding
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // buffer state
    logic [7:0]         head_reg [tes_pkg::HEAD_DEPTH];
    logic [2:0]         byte_count_reg;
    tes_pkg::tes_scan_t scan_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] encoding_reg;

    logic               out_free;
    logic               proc;
    logic [7:0]         head_next [tes_pkg::HEAD_DEPTH];
    logic [2:0]         byte_count_next;
    tes_pkg::tes_scan_t scan_next;
    logic [2:0]         encoding_next;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // a held byte steps unless it is a last byte with the result slot busy
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign in_ready = !in_valid_reg || proc;

    // header capture, bytes beyond a short buffer stay zero
    always_comb
    begin
        for (int i = 0; i < tes_pkg::HEAD_DEPTH; i++)
        begin
            head_next[i] = head_reg[i];
        end
        byte_count_next = byte_count_reg;
        if (byte_count_reg < tes_pkg::HEAD_FULL)
        begin
            head_next[byte_count_reg[1:0]] = in_byte_reg;
            byte_count_next                = byte_count_reg + 3'd1;
        end
    end

    assign scan_next     = tes_pkg::scan_byte(scan_reg, in_byte_reg);
    assign encoding_next = tes_pkg::decide(head_next[0], head_next[1], head_next[2],
                                           head_next[3], scan_next.flags);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last;
        end
    end

    // buffer state, back to reset values after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tes_pkg::HEAD_DEPTH; i++)
            begin
                head_reg[i] <= 8'd0;
            end
            byte_count_reg <= 3'd0;
            scan_reg       <= '0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                for (int i = 0; i < tes_pkg::HEAD_DEPTH; i++)
                begin
                    head_reg[i] <= 8'd0;
                end
                byte_count_reg <= 3'd0;
                scan_reg       <= '0;
            end
            else
            begin
                for (int i = 0; i < tes_pkg::HEAD_DEPTH; i++)
                begin
                    head_reg[i] <= head_next[i];
                end
                byte_count_reg <= byte_count_next;
                scan_reg       <= scan_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            encoding_reg <= encoding_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign encoding  = encoding_reg;

    // header count never passes the capture depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= tes_pkg::HEAD_FULL)
        else $error("byte count out of range");

    // a stopped scan holds no pending continuations
    a_stop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg.stopped |-> (scan_reg.pending == 2'd0))
        else $error("pending continuations after scan stop");

    // a last byte starts the next buffer from a clean state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> (byte_count_reg == 3'd0 && scan_reg == '0))
        else $error("state not cleared after last byte");

    // input only stalls on a last byte behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !out_ready))
        else $error("input stalled without cause");

    // result codes stay within the defined set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (encoding <= tes_pkg::ENC_UTF16BE))
        else $error("encoding code out of range");

endmodule
`default_nettype wire
